>>> rtl/core/bhpq_pkg.sv
// shared types and constants for the binary heap priority queue
package bhpq_pkg;

    localparam int unsigned CAPACITY_DEF = 64;
    localparam int unsigned KEY_BITS_DEF = 32;
    localparam int unsigned TAG_BITS_DEF = 16;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        CFG_LARGEST_FIRST = 1'b0,
        CFG_MATCH_MODE    = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FILL_RD,
        S_FILL_WR,
        S_UP_RD,
        S_UP_CHK,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CHK,
        S_PLACE,
        S_TOP_RD,
        S_DONE
    } t_state;

endpackage

>>> rtl/core/binary_heap_priority_queue_unit.sv
// binary heap priority queue: sequencer, heap memory and the shared key comparator
//
// One request is taken at a time; o_stall is low only while the unit is idle
// and no result word waits. A push sifts the new word up from the last slot, a
// pop moves the last slot to the root and sifts it down, a remove scans the
// slots from zero for the first match, refills the freed slot from the last one,
// sifts it up and then sifts down at the freed slot. The moving word stays in a
// register while it travels; it is written at its first slot and once more at
// its final slot. All heap traffic goes through one single-port memory with a
// registered read, and every sift step uses the one key comparator, so the cost
// is set by memory accesses. A push climbs one level per parent read and check,
// a pop descends one level per read of both children and check, up to
// log2(CAPACITY) levels. A remove reads and checks each scanned slot, then runs
// the refill, its sift up, one placing write, its sift down and the end of the
// request. Full, empty and miss at the door, and the unused request type, go
// straight to the read of the new top. Every request ends with a read of the new
// top and the result word, after a placing write if a word was moved. Ties in key
// are never swapped. The result word is held in an output register until taken.
// Configuration words are taken only while the sequencer is idle.
module binary_heap_priority_queue_unit #(
    parameter int unsigned CAPACITY = bhpq_pkg::CAPACITY_DEF,
    parameter int unsigned KEY_BITS = bhpq_pkg::KEY_BITS_DEF,
    parameter int unsigned TAG_BITS = bhpq_pkg::TAG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [KEY_BITS-1:0]           i_item_key,
    input  logic [TAG_BITS-1:0]           i_item_tag,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [KEY_BITS-1:0]           o_taken_key,
    output logic [TAG_BITS-1:0]           o_taken_tag,
    output logic                          o_top_valid,
    output logic [KEY_BITS-1:0]           o_top_key,
    output logic [TAG_BITS-1:0]           o_top_tag,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic                          i_cfg_data
);
    import bhpq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = KEY_BITS + TAG_BITS;

    // heap memory, one port, registered read
    logic [EW-1:0] r_mem [CAPACITY];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    // control and working registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_largest, r_match_tag;
    logic [1:0]    r_req, n_req;
    logic [EW-1:0] r_item, n_item;       // request word, then the moving word
    logic [AW-1:0] r_pos, n_pos;         // slot of the moving word
    logic [AW-1:0] r_other, n_other;     // parent or left child slot
    logic [EW-1:0] r_best, n_best;       // left child word
    logic          r_best_ok, n_best_ok;
    logic          r_dn_after, n_dn_after; // remove: sift down after sift up
    logic [AW-1:0] r_origin, n_origin;   // remove: refilled slot
    logic [EW-1:0] r_after, n_after;     // remove: word left at the refilled slot
    logic [1:0]    r_status, n_status;
    logic [EW-1:0] r_taken, n_taken;
    logic          r_ovalid, n_ovalid;
    logic [EW-1:0] r_top, n_top;

    // shared comparator: does key a rank above key b
    logic [KEY_BITS-1:0] cmp_a, cmp_b;
    logic                cmp_above;
    assign cmp_above = r_largest ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

    logic [CW:0]   left_w, right_w;
    logic [AW-1:0] parent_w;
    logic [EW-1:0] req_word;
    logic          scan_hit;
    logic          right_win;

    assign left_w   = (CW+1)'({r_pos, 1'b1});
    assign right_w  = left_w + 1'b1;
    assign parent_w = (r_pos - 1'b1) >> 1;
    assign req_word = {i_item_key, i_item_tag};
    assign scan_hit = (r_rd[TAG_BITS-1:0] == r_item[TAG_BITS-1:0]) &&
                      (r_match_tag || r_rd[EW-1:TAG_BITS] == r_item[EW-1:TAG_BITS]);
    // right child exists and beats the best so far (meaningful in S_DN_CHK)
    assign right_win = (right_w < (CW+1)'(r_count)) && cmp_above;

    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_cfg_ready = (r_state == S_IDLE);

    // comparator operands by step
    always_comb begin
        cmp_a = r_item[EW-1:TAG_BITS];
        cmp_b = r_rd[EW-1:TAG_BITS];
        case (r_state)
            S_DN_RDR: begin
                // left child against the moving word
                cmp_a = r_rd[EW-1:TAG_BITS];
                cmp_b = r_item[EW-1:TAG_BITS];
            end
            S_DN_CHK: begin
                // right child against the best so far
                cmp_a = r_rd[EW-1:TAG_BITS];
                cmp_b = r_best_ok ? r_best[EW-1:TAG_BITS] : r_item[EW-1:TAG_BITS];
            end
            default: begin
                // moving word against its parent
                cmp_a = r_item[EW-1:TAG_BITS];
                cmp_b = r_rd[EW-1:TAG_BITS];
            end
        endcase
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;  n_count = r_count;  n_req = r_req;  n_item = r_item;
        n_pos = r_pos;  n_other = r_other;  n_best = r_best;  n_best_ok = r_best_ok;
        n_dn_after = r_dn_after;  n_status = r_status;  n_taken = r_taken;
        n_ovalid = r_ovalid;  n_top = r_top;  n_origin = r_origin;  n_after = r_after;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_req = i_req_type;  n_item = req_word;
                    n_status = ST_OK;  n_taken = '0;  n_dn_after = 1'b0;
                    case (t_req'(i_req_type))
                        REQ_PUSH: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;  n_state = S_TOP_RD;
                            end else begin
                                n_pos = r_count[AW-1:0];
                                n_count = r_count + 1'b1;
                                n_state = S_FILL_WR;
                            end
                        end
                        REQ_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;  n_state = S_TOP_RD;
                            end else begin
                                n_pos = '0;  n_state = S_SCAN_RD;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;  n_state = S_TOP_RD;
                            end else begin
                                n_pos = '0;  n_state = S_SCAN_RD;
                            end
                        end
                        default: n_state = S_TOP_RD;
                    endcase
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (r_req == REQ_POP || scan_hit) begin
                    n_taken = r_rd;
                    n_count = r_count - 1'b1;
                    if (CW'(r_pos) == r_count - 1'b1) begin
                        n_state = S_TOP_RD;
                    end else begin
                        n_dn_after = (r_req == REQ_REMOVE);
                        n_state = S_FILL_RD;
                    end
                end else if (CW'(r_pos) + 1'b1 == r_count) begin
                    n_status = ST_NOT_FOUND;  n_state = S_TOP_RD;
                end else begin
                    n_pos = r_pos + 1'b1;  n_state = S_SCAN_RD;
                end
            end
            S_FILL_RD: n_state = S_FILL_WR;
            S_FILL_WR: begin
                if (r_req != REQ_PUSH) begin
                    n_item = r_rd;
                end
                n_origin = r_pos;
                n_after = r_rd;
                n_state = (r_req == REQ_POP) ? S_DN_RDL : S_UP_RD;
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    n_state = S_PLACE;
                end else begin
                    n_other = parent_w;
                    n_state = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (cmp_above) begin
                    // parent moves down into the moving word's slot
                    if (r_pos == r_origin) begin
                        n_after = r_rd;
                    end
                    n_pos = r_other;  n_state = S_UP_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_RDL: begin
                if (left_w < (CW+1)'(r_count)) begin
                    n_other = left_w[AW-1:0];  n_best_ok = 1'b0;
                    n_state = S_DN_RDR;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_RDR: begin
                // left child data arrives now
                n_best = r_rd;
                n_best_ok = cmp_above;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (right_win) begin
                    n_pos = right_w[AW-1:0];  n_state = S_DN_RDL;
                end else if (r_best_ok) begin
                    n_pos = r_other;  n_state = S_DN_RDL;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                // moving word written at its slot; remove then sifts down at the refilled slot
                if (r_dn_after) begin
                    n_pos = r_origin;  n_item = r_after;  n_dn_after = 1'b0;
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_TOP_RD;
                end
            end
            S_TOP_RD: n_state = S_DONE;
            S_DONE: begin
                n_top = r_rd;  n_ovalid = 1'b1;  n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;  mem_addr = r_pos;  mem_wd = r_item;
        case (r_state)
            S_FILL_RD:  mem_addr = AW'(r_count);
            S_FILL_WR: begin
                mem_we = 1'b1;  mem_addr = r_pos;
                mem_wd = (r_req == REQ_PUSH) ? r_item : r_rd;
            end
            S_UP_RD:    mem_addr = parent_w;
            S_UP_CHK: begin
                mem_we = cmp_above;  mem_addr = r_pos;  mem_wd = r_rd;
            end
            S_DN_RDL:   mem_addr = left_w[AW-1:0];
            S_DN_RDR:   mem_addr = right_w[AW-1:0];
            S_DN_CHK: begin
                mem_we = right_win || r_best_ok;  mem_addr = r_pos;
                mem_wd = right_win ? r_rd : r_best;
            end
            S_PLACE: begin
                mem_we = 1'b1;  mem_addr = r_pos;  mem_wd = r_item;
            end
            S_TOP_RD:   mem_addr = '0;
            default:    mem_addr = r_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_count <= '0;  r_ovalid <= 1'b0;
            r_largest <= 1'b0;  r_match_tag <= 1'b0;
        end else begin
            r_state <= n_state;  r_count <= n_count;  r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (t_cfg_idx'(i_cfg_index) == CFG_LARGEST_FIRST) r_largest <= i_cfg_data;
                else r_match_tag <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;  r_item <= n_item;  r_pos <= n_pos;  r_other <= n_other;
        r_best <= n_best;  r_best_ok <= n_best_ok;  r_dn_after <= n_dn_after;
        r_status <= n_status;  r_taken <= n_taken;  r_top <= n_top;
        r_origin <= n_origin;  r_after <= n_after;
    end

    // result word
    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_taken_key   = r_taken[EW-1:TAG_BITS];
    assign o_taken_tag   = r_taken[TAG_BITS-1:0];
    assign o_top_valid   = (r_count != '0);
    assign o_top_key     = o_top_valid ? r_top[EW-1:TAG_BITS] : '0;
    assign o_top_tag     = o_top_valid ? r_top[TAG_BITS-1:0] : '0;
    assign o_entry_count = r_count;

endmodule

>>> rtl/core/bhpq_checker.sv
// port-level checker for the binary heap priority queue, with its bind
module bhpq_port_props #(
    parameter int unsigned CNT_W = 7
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [1:0]       o_status,
    input logic             o_top_valid,
    input logic [CNT_W-1:0] o_entry_count
);

    // a held result word keeps its status and entry count
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_entry_count))
        else $error("result word changed while stalled");

    // top valid tracks a nonzero count
    a_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_top_valid == (o_entry_count != '0)))
        else $error("top valid disagrees with count");

    // the unit takes no request while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while a result waits");

endmodule

bind binary_heap_priority_queue_unit bhpq_port_props #(
    .CNT_W($clog2(CAPACITY + 1))
) u_bhpq_port_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_top_valid(o_top_valid), .o_entry_count(o_entry_count)
);
